/* sv/nfps_pkg.sv */
`default_nettype none

package nfps_pkg;

  localparam int IdxW   = 11;
  localparam int CoordW = 24;
  localparam int DiffW  = CoordW + 1;
  localparam int SqW    = 2 * CoordW + 1;
  localparam int DistW  = 50;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_QUERY_X = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUERY_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_QUERY_Z = 2'd2;

  typedef struct packed {
    logic            valid;
    logic            removed;
    logic            last;
    logic [IdxW-1:0] idx;
  } nfps_tag_t;

endpackage

`default_nettype wire

/* sv/nfps_dist.sv */
`default_nettype none

module nfps_dist
  import nfps_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire nfps_tag_t                tag_i,
  input  wire logic signed [CoordW-1:0] point_x_i,
  input  wire logic signed [CoordW-1:0] point_y_i,
  input  wire logic signed [CoordW-1:0] point_z_i,
  input  wire logic signed [CoordW-1:0] query_x_i,
  input  wire logic signed [CoordW-1:0] query_y_i,
  input  wire logic signed [CoordW-1:0] query_z_i,
  output nfps_tag_t                     tag_o,
  output logic [DistW-1:0]              dist_o
);

  nfps_tag_t                 s1_tag_q, s2_tag_q, s3_tag_q;
  logic signed [CoordW-1:0]  s1_x_q, s1_y_q, s1_z_q;
  logic signed [DiffW-1:0]   dx, dy, dz;
  logic signed [2*DiffW-1:0] px, py, pz;
  logic [SqW-1:0]            s2_sx_q, s2_sy_q, s2_sz_q;
  logic [DistW-1:0]          sum_d;
  logic [DistW-1:0]          s3_dist_q;

  assign dx = DiffW'(query_x_i) - DiffW'(s1_x_q);
  assign dy = DiffW'(query_y_i) - DiffW'(s1_y_q);
  assign dz = DiffW'(query_z_i) - DiffW'(s1_z_q);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign sum_d = DistW'(s2_sx_q) + DistW'(s2_sy_q) + DistW'(s2_sz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
    end else if (en_i) begin
      s1_tag_q <= tag_i;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_x_q    <= point_x_i;
      s1_y_q    <= point_y_i;
      s1_z_q    <= point_z_i;
      s2_sx_q   <= px[SqW-1:0];
      s2_sy_q   <= py[SqW-1:0];
      s2_sz_q   <= pz[SqW-1:0];
      s3_dist_q <= sum_d;
    end
  end

  assign tag_o  = s3_tag_q;
  assign dist_o = s3_dist_q;

endmodule

`default_nettype wire

/* sv/nearest_four_point_select_unit.sv */
// Path: the distance of an accepted item passes the point, square and sum registers
// to reach the last stage; the kept entries of a final item are loaded into the
// result buffer as it leaves the last stage and then appear on the output.
// Throughput: one item per cycle unless stalled; a final item holds in the last stage
// until the prior result buffer drains (one result per cycle when not stalled).
// Reset (rst_ni low, asynchronous) clears the pipeline valids, the kept count,
// the result count and the query point.
`default_nettype none

module nearest_four_point_select_unit
  import nfps_pkg::*;
#(
  parameter int KEEP_SLOTS = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [CoordW-1:0]        cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [IdxW-1:0]          entry_index_i,
  input  wire logic signed [CoordW-1:0] point_x_i,
  input  wire logic signed [CoordW-1:0] point_y_i,
  input  wire logic signed [CoordW-1:0] point_z_i,
  input  wire logic                     removed_i,
  input  wire logic                     final_entry_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [IdxW-1:0]               found_index_o,
  output logic [DistW-1:0]              found_distance_o,
  output logic                          found_valid_o,
  output logic                          run_end_o
);

  localparam int SW = (KEEP_SLOTS > 1) ? $clog2(KEEP_SLOTS) : 1;
  localparam int CW = $clog2(KEEP_SLOTS + 1);
  localparam int P  = 1 << $clog2(KEEP_SLOTS);

  logic signed [CoordW-1:0] query_x_q, query_y_q, query_z_q;

  nfps_tag_t        in_tag, s3_tag;
  logic [DistW-1:0] s3_dist;
  logic             advance;
  logic             buf_free;
  logic             out_ok;
  logic             take;
  logic             load;

  logic [IdxW-1:0]  kept_idx_q  [KEEP_SLOTS];
  logic [DistW-1:0] kept_dist_q [KEEP_SLOTS];
  logic [IdxW-1:0]  kept_idx_d  [KEEP_SLOTS];
  logic [DistW-1:0] kept_dist_d [KEEP_SLOTS];
  logic [CW-1:0]    count_q, count_d;

  logic [DistW-1:0] tv [P];
  logic [SW-1:0]    ti [P];

  logic [IdxW-1:0]  buf_idx_q  [KEEP_SLOTS];
  logic [DistW-1:0] buf_dist_q [KEEP_SLOTS];
  logic [CW-1:0]    out_left_q;
  logic [SW-1:0]    out_ptr_q;
  logic             out_none_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
      query_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_QUERY_X: query_x_q <= cfg_data_i;
        CFG_QUERY_Y: query_y_q <= cfg_data_i;
        CFG_QUERY_Z: query_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_tag = '{valid: in_valid_i, removed: removed_i, last: final_entry_i,
                    idx: entry_index_i};

  nfps_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .tag_i     (in_tag),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .query_x_i (query_x_q),
    .query_y_i (query_y_q),
    .query_z_i (query_z_q),
    .tag_o     (s3_tag),
    .dist_o    (s3_dist)
  );

  assign out_valid_o = (out_left_q != '0);
  assign out_ok      = out_valid_o && !out_stall_i;
  assign buf_free    = (out_left_q == '0) || ((out_left_q == CW'(1)) && out_ok);
  assign advance     = !(s3_tag.valid && s3_tag.last && !buf_free);
  assign in_stall_o  = !advance;
  assign take        = advance && s3_tag.valid && !s3_tag.removed;
  assign load        = advance && s3_tag.valid && s3_tag.last;

  // Find the farthest kept slot, lowest slot on ties.
  always_comb begin
    for (int i = 0; i < P; i++) begin
      if (i < KEEP_SLOTS) begin
        tv[i] = kept_dist_q[i];
      end else begin
        tv[i] = '0;
      end
      ti[i] = SW'(i);
    end
    for (int s = 1; s < P; s = s * 2) begin
      for (int i = 0; i + s < P; i = i + 2 * s) begin
        if (tv[i + s] > tv[i]) begin
          tv[i] = tv[i + s];
          ti[i] = ti[i + s];
        end
      end
    end
  end

  always_comb begin
    kept_idx_d  = kept_idx_q;
    kept_dist_d = kept_dist_q;
    count_d     = count_q;
    if (take) begin
      if (count_q < CW'(KEEP_SLOTS)) begin
        kept_idx_d[count_q[SW-1:0]]  = s3_tag.idx;
        kept_dist_d[count_q[SW-1:0]] = s3_dist;
        count_d = count_q + CW'(1);
      end else if (s3_dist <= tv[0]) begin
        kept_idx_d[ti[0]]  = s3_tag.idx;
        kept_dist_d[ti[0]] = s3_dist;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kept_idx_q  <= kept_idx_d;
    kept_dist_q <= kept_dist_d;
    if (load) begin
      buf_idx_q  <= kept_idx_d;
      buf_dist_q <= kept_dist_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      out_left_q <= '0;
      out_ptr_q  <= '0;
      out_none_q <= 1'b0;
    end else begin
      count_q <= load ? '0 : count_d;
      if (load) begin
        out_left_q <= (count_d == '0) ? CW'(1) : count_d;
        out_none_q <= (count_d == '0);
        out_ptr_q  <= '0;
      end else if (out_ok) begin
        out_left_q <= out_left_q - CW'(1);
        out_ptr_q  <= out_ptr_q + SW'(1);
      end
    end
  end

  assign found_index_o    = out_none_q ? '0 : buf_idx_q[out_ptr_q];
  assign found_distance_o = out_none_q ? '0 : buf_dist_q[out_ptr_q];
  assign found_valid_o    = !out_none_q;
  assign run_end_o        = (out_left_q == CW'(1));

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(KEEP_SLOTS))
    else $error("kept count out of range");

  a_left_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_left_q <= CW'(KEEP_SLOTS))
    else $error("result count out of range");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (count_q == '0))
    else $error("kept state not cleared after final item");

  a_stall_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result buffer");

  a_none_is_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_valid_o) |-> run_end_o)
    else $error("empty-query result is not the last one");

endmodule

`default_nettype wire

/* tb/sv/nearest_four_point_select_unit_tb.sv */
`default_nettype none

module nearest_four_point_select_unit_tb;
  import nfps_pkg::*;

  localparam int KeepSlots = 4;
  localparam int IdlePct = 38;
  localparam int PhaseItems = 50;
  localparam int DrainCycles = 12;
  localparam int CycleLimit = 200000;
  localparam logic [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};

  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              removed;
    logic              last;
  } light_entry_t;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] sq_dist;
    logic             valid;
    logic             run_end;
  } pick_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index_i = CFG_QUERY_X;
  logic [CoordW-1:0]        cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [IdxW-1:0]          entry_index_i = '0;
  logic signed [CoordW-1:0] point_x_i = '0;
  logic signed [CoordW-1:0] point_y_i = '0;
  logic signed [CoordW-1:0] point_z_i = '0;
  logic                     removed_i = 1'b0;
  logic                     final_entry_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [IdxW-1:0]          found_index_o;
  logic [DistW-1:0]         found_distance_o;
  logic                     found_valid_o;
  logic                     run_end_o;

  nearest_four_point_select_unit #(
    .KEEP_SLOTS(KeepSlots)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .entry_index_i   (entry_index_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .removed_i       (removed_i),
    .final_entry_i   (final_entry_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_index_o   (found_index_o),
    .found_distance_o(found_distance_o),
    .found_valid_o   (found_valid_o),
    .run_end_o       (run_end_o)
  );

  light_entry_t     entry_backlog[$];
  light_entry_t     shown_entry;
  bit               showing = 1'b0;
  bit               steady = 1'b0;
  pick_t            due_picks[$];
  logic [CoordW-1:0] query_pt[3] = '{default: '0};
  logic [IdxW-1:0]  kept_idx[KeepSlots];
  logic [DistW-1:0] kept_dist[KeepSlots];
  int               kept_n = 0;
  int               errors = 0;
  int               cycles = 0;
  int               n_items = 0;
  int               n_removed = 0;
  int               n_queries = 0;
  int               n_picks = 0;
  int               n_empty = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DistW-1:0] axis_sq(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    logic [DistW-1:0] m;
    d = $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  task automatic absorb_entry(light_entry_t e);
    logic [DistW-1:0] d;
    int far_slot;
    pick_t r;
    if (!e.removed) begin
      d = axis_sq(query_pt[0], e.x) + axis_sq(query_pt[1], e.y) + axis_sq(query_pt[2], e.z);
      if (kept_n < KeepSlots) begin
        kept_idx[kept_n] = e.idx;
        kept_dist[kept_n] = d;
        kept_n++;
      end else begin
        far_slot = 0;
        for (int i = 1; i < KeepSlots; i++) begin
          if (kept_dist[i] > kept_dist[far_slot]) far_slot = i;
        end
        if (d <= kept_dist[far_slot]) begin
          kept_idx[far_slot] = e.idx;
          kept_dist[far_slot] = d;
        end
      end
    end
    if (e.last) begin
      n_queries++;
      if (kept_n == 0) begin
        r.idx = '0;
        r.sq_dist = '0;
        r.valid = 1'b0;
        r.run_end = 1'b1;
        due_picks = {due_picks, r};
        n_empty++;
      end
      for (int i = 0; i < kept_n; i++) begin
        r.idx = kept_idx[i];
        r.sq_dist = kept_dist[i];
        r.valid = 1'b1;
        r.run_end = (i == kept_n - 1);
        due_picks = {due_picks, r};
      end
      kept_n = 0;
    end
  endtask

  // accept side: predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      absorb_entry(shown_entry);
      n_items++;
      if (shown_entry.removed) n_removed++;
      showing = 1'b0;
    end
  end

  // hold a stalled item, otherwise present the next one or idle
  always @(negedge clk_i) begin
    if (rst_ni && !showing) begin
      if (entry_backlog.size() > 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
        shown_entry = entry_backlog.pop_front();
        showing = 1'b1;
        in_valid_i <= 1'b1;
        entry_index_i <= shown_entry.idx;
        point_x_i <= shown_entry.x;
        point_y_i <= shown_entry.y;
        point_z_i <= shown_entry.z;
        removed_i <= shown_entry.removed;
        final_entry_i <= shown_entry.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < IdlePct);
  end

  always @(posedge clk_i) begin
    pick_t got;
    pick_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.idx = found_index_o;
      got.sq_dist = found_distance_o;
      got.valid = found_valid_o;
      got.run_end = run_end_o;
      n_picks++;
      if (due_picks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result idx=%0d dist=%0d valid=%0b end=%0b",
                 $time, got.idx, got.sq_dist, got.valid, got.run_end);
      end else begin
        want = due_picks.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                   $time, want.idx, want.sq_dist, want.valid, want.run_end,
                   got.idx, got.sq_dist, got.valid, got.run_end);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_entry(int idx, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                            logic [CoordW-1:0] z, bit removed, bit last);
    light_entry_t e;
    e.idx = IdxW'(idx);
    e.x = x;
    e.y = y;
    e.z = z;
    e.removed = removed;
    e.last = last;
    entry_backlog = {entry_backlog, e};
  endtask

  task automatic drain;
    while (entry_backlog.size() > 0 || showing || due_picks.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_query(logic [CfgIdxW-1:0] sel, logic [CoordW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i <= v;
    query_pt[sel] = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CoordW-1:0] pick_coord(logic [CoordW-1:0] q);
    logic [CoordW-1:0] c;
    case ($urandom_range(0, 5))
      0, 1: c = q + CoordW'($urandom_range(0, 8)) - CoordW'(4);
      2: c = q + CoordW'($urandom_range(0, 255));
      3: c = $urandom_range(0, 1) ? CoordMin : CoordMax;
      default: c = CoordW'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic [CoordW-1:0] pick_query();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? CoordMin : CoordMax;
      1: return CoordW'($urandom_range(0, 2047)) - CoordW'(1024);
      default: return CoordW'($urandom);
    endcase
  endfunction

  initial begin
    int phase_count;
    int len;
    int del_pct;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // query point at reset: origin
    push_entry(5, 0, 0, 0, 1'b1, 1'b1);
    push_entry(17, 1, 2, 3, 1'b0, 1'b1);
    push_entry(1, 3, 0, 0, 1'b0, 1'b0);
    push_entry(2, 1, 0, 0, 1'b0, 1'b0);
    push_entry(3, 0, 3, 0, 1'b0, 1'b0);
    push_entry(4, 0, 0, 2, 1'b0, 1'b0);
    push_entry(5, 0, 0, 3, 1'b0, 1'b0);
    push_entry(6, 5, 0, 0, 1'b0, 1'b0);
    push_entry(7, 2, 0, 0, 1'b0, 1'b0);
    push_entry(8, 0, 0, 0, 1'b1, 1'b0);
    push_entry(9, 0, 0, 0, 1'b1, 1'b1);
    drain();

    write_query(CFG_QUERY_X, CoordMax);
    write_query(CFG_QUERY_Y, CoordMin);
    write_query(CFG_QUERY_Z, CoordMax);
    push_entry(2047, CoordMin, CoordMax, CoordMin, 1'b0, 1'b0);
    push_entry(0, CoordMax, CoordMin, CoordMax, 1'b0, 1'b1);
    push_entry(1024, CoordMin, CoordMin, CoordMax, 1'b0, 1'b0);
    push_entry(1023, CoordMax, CoordMax, CoordMin, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_query(CFG_QUERY_X, pick_query());
      write_query(CFG_QUERY_Y, pick_query());
      write_query(CFG_QUERY_Z, pick_query());
      steady = (p == 2);
      phase_count = 0;
      while (phase_count < PhaseItems) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 9);
        del_pct = ($urandom_range(0, 9) == 0) ? 100 : 20;
        for (int i = 0; i < len; i++) begin
          push_entry($urandom_range(0, 2047), pick_coord(query_pt[0]), pick_coord(query_pt[1]),
                     pick_coord(query_pt[2]), $urandom_range(0, 99) < del_pct, i == len - 1);
        end
        phase_count += len;
      end
      drain();
    end
    steady = 1'b0;

    $display("Covered %0d items (%0d deleted) in %0d queries; %0d results checked, %0d empty.",
             n_items, n_removed, n_queries, n_picks, n_empty);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* nearest_four_point_select_unit.f */
sv/nfps_pkg.sv
sv/nfps_dist.sv
sv/nearest_four_point_select_unit.sv
tb/sv/nearest_four_point_select_unit_tb.sv
